// ===== rtl/core/splm_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the stereo peak level meter
// no dependencies
package splm_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int LANES = 2;
	localparam int LANE_L = 0;
	localparam int LANE_R = 1;

	localparam int DECAY_W = 8;
	localparam logic [DECAY_W-1:0] DECAY_RESET = 8'd24;

	localparam int DB_W = 12;
	localparam logic signed [DB_W-1:0] FLOOR_DB = -12'sd1536;
	localparam logic signed [DB_W-1:0] MIN_DB = -12'sd1600;

	// log2 by repeated squaring of a Q30 mantissa
	localparam int FRAC_BITS = 16;
	localparam int SQ_STAGES = FRAC_BITS;
	localparam int X_W = 31;
	localparam int P_W = 5;

	// attenuation = span * round(320*log10(2) * 2^16) / 2^32, rounded
	localparam int DIST_W = 21;
	localparam int SCALE_W = 23;
	localparam logic [SCALE_W-1:0] LOG_SCALE = 23'd6313057;
	localparam int PROD_W = DIST_W + SCALE_W;
	localparam int ATT_SHIFT = 32;
	localparam int ATT_W = PROD_W + 1 - ATT_SHIFT;
	localparam logic [ATT_W-1:0] ATT_MAX = 13'd1600;

	typedef logic signed [DB_W-1:0] db_t;

	typedef struct packed {
		logic                 fl;
		logic [P_W-1:0]       p;
		logic [X_W-1:0]       x;
		logic [FRAC_BITS-1:0] frac;
	} log_t;

endpackage

// ===== rtl/core/splm_ifs.sv =====
`timescale 1ns / 1ps
// channel interfaces: frame input, level result, decay configuration
// depends on splm_pkg
interface splm_frame_if #(
	parameter int SAMPLE_BITS = splm_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_sample;
	logic signed [SAMPLE_BITS-1:0] right_sample;
	logic                          mono;
	logic                          last_in_buffer;

	modport source (output valid, left_sample, right_sample, mono, last_in_buffer,
		input ready);
	modport sink (input valid, left_sample, right_sample, mono, last_in_buffer,
		output ready);
endinterface

interface splm_level_if ();
	logic                             valid;
	logic                             ready;
	logic signed [splm_pkg::DB_W-1:0] level_left_db;
	logic signed [splm_pkg::DB_W-1:0] level_right_db;

	modport source (output valid, level_left_db, level_right_db, input ready);
	modport sink (input valid, level_left_db, level_right_db, output ready);
endinterface

interface splm_cfg_if ();
	logic                            valid;
	logic                            ready;
	logic [splm_pkg::DECAY_W-1:0]    decay_step;

	modport source (output valid, decay_step, input ready);
	modport sink (input valid, decay_step, output ready);
endinterface

// ===== rtl/core/stereo_peak_level_meter_db.sv =====
`timescale 1ns / 1ps
// stereo peak level meter in 1/16 dB with per-buffer decay, top level
// depends on splm_pkg, splm_ifs, splm_peak, splm_db_conv
//
// channel  dir  payload                                         transfer
// frame    in   left_sample, right_sample, mono, last_in_buffer  valid && ready
// level    out  level_left_db, level_right_db                   valid && ready
// cfg      in   decay_step                                      valid && ready (ready = 1)
//
// one frame per cycle sustained while the level output keeps up; frames without last_in_buffer only update the peaks
// a level result passes from its last frame transfer through the snapshot, 20 stages
// (leading one, normalize, 16 squaring multipliers, scale multiply, round) and the output register
// reset: peaks 0, held levels -96 dB, decay_step 24
// a stalled level output backs up the stages; frames keep flowing while bubbles remain
module stereo_peak_level_meter_db #(
	parameter int SAMPLE_BITS = splm_pkg::SAMPLE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	splm_frame_if.sink   frame,
	splm_level_if.source level,
	splm_cfg_if.sink     cfg
);
	import splm_pkg::*;

	logic                   pk_valid;
	logic                   pk_ready;
	logic [SAMPLE_BITS-2:0] pk_mag [LANES];
	logic                   db_valid;
	logic                   db_ready;
	db_t                    db_lvl [LANES];

	logic [DECAY_W-1:0]     decay_q;
	db_t                    held_q [LANES];
	db_t                    lvl_q [LANES];
	logic                   out_v_q;
	logic                   hv;
	logic signed [DB_W:0]   dec [LANES];
	db_t                    held_n [LANES];

	splm_peak #(.SAMPLE_BITS(SAMPLE_BITS)) u_peak (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (frame.valid),
		.in_ready       (frame.ready),
		.left_sample    (frame.left_sample),
		.right_sample   (frame.right_sample),
		.mono           (frame.mono),
		.last_in_buffer (frame.last_in_buffer),
		.snap_valid     (pk_valid),
		.snap_ready     (pk_ready),
		.snap_mag       (pk_mag)
	);

	splm_db_conv #(.SAMPLE_BITS(SAMPLE_BITS)) u_db (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pk_valid),
		.up_ready (pk_ready),
		.up_mag   (pk_mag),
		.dn_valid (db_valid),
		.dn_ready (db_ready),
		.dn_db    (db_lvl)
	);

	assign cfg.ready = 1'b1;
	assign db_ready = !out_v_q || level.ready;
	assign hv = db_valid && db_ready;

	assign level.valid = out_v_q;
	assign level.level_left_db = lvl_q[LANE_L];
	assign level.level_right_db = lvl_q[LANE_R];

	// held level minus decay, then the larger of that and the new reading
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			dec[l] = {held_q[l][DB_W-1], held_q[l]}
				- {{(DB_W + 1 - DECAY_W){1'b0}}, decay_q};
			held_n[l] = ($signed({db_lvl[l][DB_W-1], db_lvl[l]}) > dec[l])
				? db_lvl[l] : dec[l][DB_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RESET;
			out_v_q <= 1'b0;
			for (int l = 0; l < LANES; l++) begin
				held_q[l] <= FLOOR_DB;
			end
		end else begin
			if (cfg.valid) begin
				decay_q <= cfg.decay_step;
			end
			if (hv) begin
				out_v_q <= 1'b1;
				held_q <= held_n;
			end else if (level.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hv) begin
			lvl_q <= held_n;
		end
	end

	a_out_matches_held: assert property (@(posedge clk) disable iff (!arst_n)
		hv |=> level.valid && level.level_left_db == held_q[LANE_L]
			&& level.level_right_db == held_q[LANE_R])
		else $error("level output differs from held level");

	a_held_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!hv |=> $stable(held_q[LANE_L]) && $stable(held_q[LANE_R]))
		else $error("held level changed without a result");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q[LANE_L] <= 0 && held_q[LANE_L] >= MIN_DB
			&& held_q[LANE_R] <= 0 && held_q[LANE_R] >= MIN_DB)
		else $error("held level out of range");

endmodule

// ===== rtl/core/splm_sq_step.sv =====
`timescale 1ns / 1ps
// one squaring step of the log2 fraction: square the mantissa, emit one bit
// depends on splm_pkg
module splm_sq_step (
	input  logic            clk,
	input  logic            ld,
	input  splm_pkg::log_t  d,
	output splm_pkg::log_t  q
);
	import splm_pkg::*;

	logic [2*X_W-1:0] sq;
	logic [X_W:0]     t;
	logic             hi;
	log_t             nx;

	always_comb begin
		sq = d.x * d.x;
		t = sq[2*X_W-1:X_W-1];
		hi = t[X_W];
		nx.fl = d.fl;
		nx.p = d.p;
		nx.x = hi ? t[X_W:1] : t[X_W-1:0];
		nx.frac = {d.frac[FRAC_BITS-2:0], hi};
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			q <= nx;
		end
	end

endmodule

// ===== rtl/core/splm_peak.sv =====
`timescale 1ns / 1ps
// per-channel peak magnitude tracking and snapshot at buffer end
// depends on splm_pkg
module splm_peak #(
	parameter int SAMPLE_BITS = splm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          mono,
	input  logic                          last_in_buffer,
	output logic                          snap_valid,
	input  logic                          snap_ready,
	output logic [SAMPLE_BITS-2:0]        snap_mag [splm_pkg::LANES]
);
	import splm_pkg::*;

	localparam int MAG_W = SAMPLE_BITS - 1;
	localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {MAG_W{1'b0}}};

	function automatic logic [MAG_W-1:0] mag_of(input logic [SAMPLE_BITS-1:0] s);
		logic [SAMPLE_BITS-1:0] neg;
		neg = ~s + 1'b1;
		if (s == MOST_NEG) begin
			return '1;
		end else if (s[SAMPLE_BITS-1]) begin
			return neg[MAG_W-1:0];
		end else begin
			return s[MAG_W-1:0];
		end
	endfunction

	logic             acc;
	logic             snap_v_q;
	logic [MAG_W-1:0] mag [LANES];
	logic [MAG_W-1:0] upd [LANES];
	logic [MAG_W-1:0] peak_q [LANES];
	logic [MAG_W-1:0] snap_q [LANES];

	assign in_ready = !snap_v_q || snap_ready;
	assign acc = in_valid && in_ready;
	assign snap_valid = snap_v_q;
	assign snap_mag = snap_q;

	always_comb begin
		mag[LANE_L] = mag_of(left_sample);
		mag[LANE_R] = mono ? mag[LANE_L] : mag_of(right_sample);
		for (int l = 0; l < LANES; l++) begin
			upd[l] = (mag[l] > peak_q[l]) ? mag[l] : peak_q[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_v_q <= 1'b0;
			for (int l = 0; l < LANES; l++) begin
				peak_q[l] <= '0;
			end
		end else begin
			if (acc && last_in_buffer) begin
				snap_v_q <= 1'b1;
			end else if (snap_ready) begin
				snap_v_q <= 1'b0;
			end
			if (acc) begin
				for (int l = 0; l < LANES; l++) begin
					peak_q[l] <= last_in_buffer ? '0 : upd[l];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last_in_buffer) begin
			snap_q <= upd;
		end
	end

	a_peak_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_in_buffer |=> peak_q[LANE_L] == '0 && peak_q[LANE_R] == '0 && snap_v_q)
		else $error("peaks not cleared at buffer end");

	a_peak_grow: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !last_in_buffer |=> peak_q[LANE_L] >= $past(peak_q[LANE_L])
			&& peak_q[LANE_R] >= $past(peak_q[LANE_R]))
		else $error("peak decreased inside a buffer");

	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		snap_v_q && !snap_ready |=> snap_v_q && $stable(snap_q[LANE_L])
			&& $stable(snap_q[LANE_R]))
		else $error("snapshot lost while stalled");

endmodule

// ===== rtl/core/splm_db_conv.sv =====
`timescale 1ns / 1ps
// pipelined peak magnitude to 1/16 dB conversion for both channels
// depends on splm_pkg, splm_sq_step
module splm_db_conv #(
	parameter int SAMPLE_BITS = splm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   up_valid,
	output logic                   up_ready,
	input  logic [SAMPLE_BITS-2:0] up_mag [splm_pkg::LANES],
	output logic                   dn_valid,
	input  logic                   dn_ready,
	output splm_pkg::db_t          dn_db [splm_pkg::LANES]
);
	import splm_pkg::*;

	localparam int MAG_W = SAMPLE_BITS - 1;
	localparam int NST = SQ_STAGES + 4;
	localparam int SQ_FIRST = 3;
	localparam longint unsigned FULL_SCALE = 64'd1 << MAG_W;
	localparam logic [MAG_W-1:0] FLOOR_MAG = MAG_W'(FULL_SCALE / 100000);
	localparam logic [DIST_W-1:0] DIST_TOP = DIST_W'(MAG_W * (2 ** FRAC_BITS));
	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(64'd1 << (ATT_SHIFT - 1));

	function automatic logic [P_W-1:0] lead_one(input logic [MAG_W-1:0] m);
		logic [P_W-1:0] p;
		p = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (m[i]) begin
				p = P_W'(i);
			end
		end
		return p;
	endfunction

	logic [NST:1]   v_q;
	logic [NST:1]   vin;
	logic [NST+1:1] ld;

	logic [MAG_W-1:0]  m_s1 [LANES];
	logic [P_W-1:0]    p_s1 [LANES];
	logic              fl_s1 [LANES];
	log_t              lg_s2 [LANES];
	log_t              lg_sq [LANES][SQ_STAGES+1];
	logic [PROD_W-1:0] prod_s19 [LANES];
	logic              fl_s19 [LANES];
	db_t               db_s20 [LANES];

	assign vin = {v_q[NST-1:1], up_valid};
	assign ld[NST+1] = dn_ready;
	assign up_ready = ld[1];
	assign dn_valid = v_q[NST];
	assign dn_db = db_s20;

	for (genvar i = 1; i <= NST; i++) begin : g_ld
		assign ld[i] = !v_q[i] || ld[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 1; i <= NST; i++) begin
				if (ld[i]) begin
					v_q[i] <= vin[i];
				end
			end
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [DIST_W-1:0] span;
		logic [PROD_W:0]   sum;
		logic [ATT_W-1:0]  att;
		logic [ATT_W-1:0]  attc;
		logic signed [ATT_W:0] neg;

		always_comb begin
			span = DIST_TOP - DIST_W'({lg_sq[l][SQ_STAGES].p, lg_sq[l][SQ_STAGES].frac});
			sum = {1'b0, prod_s19[l]} + ROUND_HALF;
			att = sum[PROD_W:ATT_SHIFT];
			attc = (att > ATT_MAX) ? ATT_MAX : att;
			neg = -$signed({1'b0, attc});
		end

		always_ff @(posedge clk) begin
			if (ld[1]) begin
				m_s1[l] <= up_mag[l];
				p_s1[l] <= lead_one(up_mag[l]);
				fl_s1[l] <= (up_mag[l] <= FLOOR_MAG);
			end
			if (ld[2]) begin
				lg_s2[l].fl <= fl_s1[l];
				lg_s2[l].p <= p_s1[l];
				lg_s2[l].x <= X_W'(m_s1[l]) << (P_W'(X_W - 1) - p_s1[l]);
				lg_s2[l].frac <= '0;
			end
			if (ld[NST-1]) begin
				prod_s19[l] <= PROD_W'(span) * PROD_W'(LOG_SCALE);
				fl_s19[l] <= lg_sq[l][SQ_STAGES].fl;
			end
			if (ld[NST]) begin
				db_s20[l] <= fl_s19[l] ? FLOOR_DB : neg[DB_W-1:0];
			end
		end

		assign lg_sq[l][0] = lg_s2[l];

		for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
			splm_sq_step u_sq (
				.clk (clk),
				.ld  (ld[SQ_FIRST+k]),
				.d   (lg_sq[l][k]),
				.q   (lg_sq[l][k+1])
			);
		end
	end

	a_zero_floor: assert property (@(posedge clk) disable iff (!arst_n)
		up_valid && up_ready && up_mag[LANE_L] == '0 && up_mag[LANE_R] == '0
			|=> fl_s1[LANE_L] && fl_s1[LANE_R])
		else $error("silent peak not flagged as floor");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NST] && !dn_ready |=> v_q[NST] && $stable(db_s20[LANE_L])
			&& $stable(db_s20[LANE_R]))
		else $error("converted level lost while stalled");

	a_db_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NST] |-> db_s20[LANE_L] <= 0 && db_s20[LANE_L] >= MIN_DB
			&& db_s20[LANE_R] <= 0 && db_s20[LANE_R] >= MIN_DB)
		else $error("converted level out of range");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for stereo_peak_level_meter_db: directed and random frames under varying
// handshake pressure, levels predicted in a scoreboard class and checked per field
// depends on splm_pkg, splm_ifs and the rtl top level
module tb_top;
	import splm_pkg::*;

	class level_scoreboard;
		logic [22:0] peak_l, peak_r;
		int held_l, held_r;
		logic [DECAY_W-1:0] decay;
		db_t want_l[$], want_r[$];
		int frames_seen, levels_checked, mismatches;

		function new();
			peak_l = 0;
			peak_r = 0;
			held_l = FLOOR_DB;
			held_r = FLOOR_DB;
			decay = DECAY_RESET;
			frames_seen = 0;
			levels_checked = 0;
			mismatches = 0;
		endfunction

		function void set_decay(logic [DECAY_W-1:0] v);
			decay = v;
		endfunction

		// most negative sample saturates to full scale minus one
		function logic [22:0] magnitude(logic signed [23:0] s);
			logic [24:0] t;
			if (!s[23])
				return s[22:0];
			t = 25'h1000000 - {1'b0, s};
			if (t > 25'h7fffff)
				return 23'h7fffff;
			return t[22:0];
		endfunction

		// log2 by squaring a Q30 mantissa, then scaled to 1/16 dB
		function int peak_to_db(logic [22:0] m);
			longint unsigned x, span, att, mag;
			int p, frac;
			mag = m;
			if (mag == 0 || mag * 100000 <= 64'd8388608)
				return FLOOR_DB;
			p = 0;
			while (p < 31 && (mag >> (p + 1)) != 0)
				p++;
			x = mag << (30 - p);
			frac = 0;
			for (int i = 0; i < 16; i++) begin
				x = (x * x) >> 30;
				frac = frac << 1;
				if (x >= 64'h80000000) begin
					frac = frac | 1;
					x = x >> 1;
				end
			end
			span = (longint'(23) << 16) - ((longint'(p) << 16) | longint'(frac));
			att = (span * 64'd6313057 + 64'h80000000) >> 32;
			if (att > 1600)
				att = 1600;
			return -int'(att);
		endfunction

		function int decay_hold(int db, int held);
			int d, r;
			d = held - int'(decay);
			r = db > d ? db : d;
			if (r < MIN_DB)
				r = MIN_DB;
			if (r > 0)
				r = 0;
			return r;
		endfunction

		function void note_frame(logic signed [23:0] ls, logic signed [23:0] rs,
				logic mono, logic last);
			logic [22:0] ml, mr;
			frames_seen++;
			ml = magnitude(ls);
			mr = mono ? ml : magnitude(rs);
			if (ml > peak_l)
				peak_l = ml;
			if (mr > peak_r)
				peak_r = mr;
			if (!last)
				return;
			held_l = decay_hold(peak_to_db(peak_l), held_l);
			held_r = decay_hold(peak_to_db(peak_r), held_r);
			peak_l = 0;
			peak_r = 0;
			want_l.push_back(db_t'(held_l));
			want_r.push_back(db_t'(held_r));
		endfunction

		function void check_level(db_t got_l, db_t got_r);
			db_t el, er;
			if (want_l.size() == 0) begin
				$display("%0t unexpected level transfer: left %0d right %0d", $time,
					got_l, got_r);
				mismatches++;
				return;
			end
			el = want_l.pop_front();
			er = want_r.pop_front();
			levels_checked++;
			if (got_l !== el) begin
				$display("%0t level_left_db: expected %0d actual %0d", $time, el, got_l);
				mismatches++;
			end
			if (got_r !== er) begin
				$display("%0t level_right_db: expected %0d actual %0d", $time, er, got_r);
				mismatches++;
			end
		endfunction

		function int pending();
			return want_l.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	level_scoreboard sb = new();

	splm_frame_if #(.SAMPLE_BITS(24)) frame_ch ();
	splm_level_if level_ch ();
	splm_cfg_if cfg_ch ();

	stereo_peak_level_meter_db #(.SAMPLE_BITS(24)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_ch),
		.level(level_ch),
		.cfg(cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("timeout with %0d levels outstanding", sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		level_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && frame_ch.valid && frame_ch.ready)
			sb.note_frame(frame_ch.left_sample, frame_ch.right_sample, frame_ch.mono,
				frame_ch.last_in_buffer);
	end

	always @(posedge clk) begin
		if (arst_n && level_ch.valid && level_ch.ready)
			sb.check_level(level_ch.level_left_db, level_ch.level_right_db);
	end

	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready)
			sb.set_decay(cfg_ch.decay_step);
	end

	task automatic send_frame(logic signed [23:0] ls, logic signed [23:0] rs, logic mono,
			logic last);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.left_sample <= ls;
		frame_ch.right_sample <= rs;
		frame_ch.mono <= mono;
		frame_ch.last_in_buffer <= last;
		do @(posedge clk); while (!frame_ch.ready);
	endtask

	// stop frames and let the pipeline empty
	task automatic drain();
		frame_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_decay(logic [DECAY_W-1:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.decay_step <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic signed [23:0] pick_sample(bit quiet);
		int sel, w;
		logic [23:0] mag;
		sel = $urandom_range(99);
		if (quiet)
			mag = 24'($urandom_range(0, 120));
		else if (sel < 5)
			return 24'h800000;
		else if (sel < 10)
			return 24'h7fffff;
		else if (sel < 15)
			mag = 24'($urandom_range(80, 90));
		else if (sel < 20)
			mag = 0;
		else begin
			w = $urandom_range(1, 23);
			mag = 24'($urandom & ((24'h1 << w) - 1));
		end
		return $urandom_range(1) ? -mag : mag;
	endfunction

	task automatic random_buffers(int count, bit mid_drain);
		int sent, len;
		bit quiet, mono_buf, m;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 5);
			quiet = ($urandom_range(4) == 0);
			mono_buf = ($urandom_range(3) == 0);
			for (int i = 0; i < len; i++) begin
				m = ($urandom_range(9) == 0) ? 1'($urandom_range(1)) : mono_buf;
				send_frame(pick_sample(quiet), pick_sample(quiet), m, i == len - 1);
			end
			sent += len;
			if (mid_drain && sent >= count / 2 && sent - len < count / 2)
				drain();
		end
	endtask

	initial begin
		logic [DECAY_W-1:0] mid_decay;
		frame_ch.valid = 1'b0;
		frame_ch.left_sample = '0;
		frame_ch.right_sample = '0;
		frame_ch.mono = 1'b0;
		frame_ch.last_in_buffer = 1'b0;
		level_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.decay_step = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: silence, full scale, saturation, threshold, mono, multi-frame buffers
		send_frame(24'sd0, 24'sd0, 1'b0, 1'b1);
		send_frame(24'sh7fffff, 24'sh800000, 1'b0, 1'b1);
		send_frame(-24'sd8388607, 24'sd8388607, 1'b0, 1'b1);
		send_frame(24'sd83, -24'sd83, 1'b0, 1'b1);
		send_frame(24'sd0, 24'sd0, 1'b0, 1'b1);
		send_frame(24'sd84, -24'sd84, 1'b0, 1'b1);
		send_frame(24'sh800000, 24'sd5, 1'b1, 1'b1);
		send_frame(24'sd100, 24'sd0, 1'b0, 1'b0);
		send_frame(24'sd0, -24'sd20000, 1'b0, 1'b0);
		send_frame(24'sd3000000, 24'sd7, 1'b0, 1'b1);
		send_frame(24'sd1, -24'sd1, 1'b0, 1'b1);
		send_frame(-24'sd4096, 24'sh7fffff, 1'b1, 1'b0);
		send_frame(24'sd12, -24'sd65536, 1'b0, 1'b1);
		send_frame(24'sd4194304, -24'sd4194304, 1'b0, 1'b1);
		for (int i = 0; i < 6; i++)
			send_frame(24'sd0, 24'sd0, 1'b0, 1'b1);
		send_frame(-24'sd1048576, 24'sd0, 1'b1, 1'b0);
		send_frame(24'sd0, 24'sd0, 1'b1, 1'b1);

		write_decay(8'd0);
		random_buffers(250, 1'b0);

		write_decay(8'd255);
		send_idle_pct = 77;
		random_buffers(250, 1'b1);

		mid_decay = DECAY_W'($urandom_range(1, 254));
		write_decay(mid_decay);
		send_idle_pct = 0;
		recv_stall_pct = 77;
		random_buffers(250, 1'b0);

		write_decay(DECAY_RESET);
		send_idle_pct = 38;
		recv_stall_pct = 38;
		random_buffers(250, 1'b0);

		drain();
		$display("%0d frames sent and %0d levels checked over four pressure phases",
			sb.frames_seen, sb.levels_checked);
		$display("decay steps used: 24, 0, 255, %0d", mid_decay);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/splm_pkg.sv
rtl/core/splm_ifs.sv
rtl/core/splm_sq_step.sv
rtl/core/splm_peak.sv
rtl/core/splm_db_conv.sv
rtl/core/stereo_peak_level_meter_db.sv
sim/tb_top.sv
